>>> rtl/ust_pkg.sv
// ----------------------------------------------------------------------------
// ust_pkg: shared types and constants of the unordered set table
// Capacity, index widths, operation codes, sequencer states and the
// request bundle that the sequencer sends to the entry store.
// ----------------------------------------------------------------------------
package ust_pkg;

   // number of values the store can hold
   localparam int CAPACITY = 64;
   // bits to address one entry, and bits to hold a count up to CAPACITY
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   // fixed widths of the transaction fields
   localparam int VALUE_W  = 32;
   localparam int MODE_W   = 2;
   localparam int ECOUNT_W = 7;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_DONE
   } ust_state_type;

   // access to the entry store: one write and one read per cycle
   typedef struct packed {
      logic               wr_en;
      logic [IDX_W-1:0]   wr_addr;
      logic [VALUE_W-1:0] wr_data;
      logic               rd_en;
      logic [IDX_W-1:0]   rd_addr;
   } ust_mem_req_type;

endpackage

>>> rtl/ust_store.sv
// ----------------------------------------------------------------------------
// ust_store: entry memory of the unordered set table
// CAPACITY words of 32 bits, one write port and one read port with a
// registered read data output. Contents are undefined until written.
// ----------------------------------------------------------------------------
module ust_store
   import ust_pkg::*;
(
   input  logic                clock,
   input  ust_mem_req_type     mem_req,
   output logic [VALUE_W-1:0]  rd_data
);

   logic [VALUE_W-1:0] mem [CAPACITY];
   logic [VALUE_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/ust_seq.sv
// ----------------------------------------------------------------------------
// ust_seq: sequencer and shared comparator of the unordered set table
// Scans the stored entries one per cycle against the requested value,
// shifts later entries down on a removal, then updates the count and
// issues one result.
// ----------------------------------------------------------------------------
module ust_seq
   import ust_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [MODE_W-1:0]           req_mode,
   input  logic signed [VALUE_W-1:0]   req_value,
   output logic                        rsp_valid,
   output logic                        rsp_success,
   output logic                        rsp_full_rejected,
   output logic [ECOUNT_W-1:0]         rsp_element_count,
   output ust_mem_req_type             mem_req,
   input  logic [VALUE_W-1:0]          rd_data
);

   localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);
   localparam logic [COUNT_W-1:0] ONE       = COUNT_W'(1);
   localparam logic [COUNT_W-1:0] TWO       = COUNT_W'(2);

   ust_state_type       state_ff, state_in;
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic [COUNT_W-1:0]  fill_count_ff, fill_count_in;
   logic [COUNT_W-1:0]  ptr_ff, ptr_in;
   logic                found_ff, found_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_success_ff, rsp_success_in;
   logic                rsp_full_ff, rsp_full_in;

   logic                accept;
   logic                valid_op;
   logic                match;
   logic                last;
   logic [COUNT_W-1:0]  shift_dst;

   assign accept    = start && (state_ff == ST_IDLE);
   assign valid_op  = (req_mode == MODE_INSERT) || (req_mode == MODE_REMOVE)
                      || (req_mode == MODE_QUERY);
   // shared comparator: read data belongs to entry ptr_ff - 1
   assign match     = (rd_data == value_ff);
   assign last      = (ptr_ff == fill_count_ff);
   assign shift_dst = ptr_ff - TWO;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (valid_op && (fill_count_ff != '0)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            if (match) begin
               if ((mode_ff == MODE_REMOVE) && !last) begin
                  state_in = ST_SHIFT;
               end else begin
                  state_in = ST_DONE;
               end
            end else if (last) begin
               state_in = ST_DONE;
            end
         end
         ST_SHIFT: begin
            if (last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath, store access and result
   always_comb begin
      mode_in         = mode_ff;
      value_in        = value_ff;
      fill_count_in   = fill_count_ff;
      ptr_in          = ptr_ff;
      found_in        = found_ff;
      rsp_valid_in    = 1'b0;
      rsp_success_in  = rsp_success_ff;
      rsp_full_in     = rsp_full_ff;
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = shift_dst[IDX_W-1:0];
      mem_req.wr_data = rd_data;
      mem_req.rd_en   = 1'b0;
      mem_req.rd_addr = ptr_ff[IDX_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in         = req_mode;
               value_in        = req_value;
               found_in        = 1'b0;
               // first read of the scan
               ptr_in          = ONE;
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = '0;
            end
         end
         ST_SCAN: begin
            if (match) begin
               found_in = 1'b1;
               // removal: start fetching the entry after the match
               if ((mode_ff == MODE_REMOVE) && !last) begin
                  mem_req.rd_en = 1'b1;
                  ptr_in        = ptr_ff + ONE;
               end
            end else if (!last) begin
               mem_req.rd_en = 1'b1;
               ptr_in        = ptr_ff + ONE;
            end
         end
         ST_SHIFT: begin
            // move the fetched entry down one place, fetch the next one
            mem_req.wr_en = 1'b1;
            if (!last) begin
               mem_req.rd_en = 1'b1;
               ptr_in        = ptr_ff + ONE;
            end
         end
         ST_DONE: begin
            rsp_valid_in   = 1'b1;
            rsp_success_in = 1'b0;
            rsp_full_in    = 1'b0;
            case (mode_ff)
               MODE_INSERT: begin
                  if (!found_ff) begin
                     if (fill_count_ff != CAP_COUNT) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = fill_count_ff[IDX_W-1:0];
                        mem_req.wr_data = value_ff;
                        fill_count_in   = fill_count_ff + ONE;
                        rsp_success_in  = 1'b1;
                     end else begin
                        rsp_full_in = 1'b1;
                     end
                  end
               end
               MODE_REMOVE: begin
                  if (found_ff) begin
                     fill_count_in  = fill_count_ff - ONE;
                     rsp_success_in = 1'b1;
                  end
               end
               MODE_QUERY: begin
                  rsp_success_in = found_ff;
               end
               default: begin
                  rsp_success_in = 1'b0;
               end
            endcase
         end
         default: begin
            ptr_in = ptr_ff;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_count_ff <= fill_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      value_ff       <= value_in;
      ptr_ff         <= ptr_in;
      found_ff       <= found_in;
      rsp_success_ff <= rsp_success_in;
      rsp_full_ff    <= rsp_full_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_success       = rsp_success_ff;
   assign rsp_full_rejected = rsp_full_ff;
   assign rsp_element_count = ECOUNT_W'(fill_count_ff);

endmodule

>>> rtl/unordered_set_table.sv
// ----------------------------------------------------------------------------
// unordered_set_table: bounded set of distinct 32-bit integers
// Packed unordered array of CAPACITY entries with insert, remove and query.
// ----------------------------------------------------------------------------
// Usage
//   Request: drive req_mode and req_value and raise start while busy is low;
//   the transaction is taken at that clock edge and busy rises.
//   Modes: insert appends a new value (duplicates rejected, full store
//   flagged on rsp_full_rejected), remove deletes a value and closes the
//   gap, query reports membership. An unused mode code is a no-op.
//   Response: rsp_valid is high for exactly one cycle with rsp_success,
//   rsp_full_rejected and rsp_element_count (count after the operation).
//   The receiver cannot stall; the result is gone after that cycle.
//   Timing: the shared comparator checks one stored entry per cycle from the
//   entry memory's single read port. A match on insert or query ends the scan
//   early, and a removal shifts the later entries down in the cycles that the
//   rest of the scan would have used, so it takes as long as a full scan. An
//   empty store or an unused mode skips the scan and goes straight to the
//   result. The next request may be given in the cycle in which rsp_valid
//   is high.
//   Reset: synchronous, clears the count to empty; memory is not cleared.
// ----------------------------------------------------------------------------
module unordered_set_table
   import ust_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [MODE_W-1:0]           req_mode,
   input  logic signed [VALUE_W-1:0]   req_value,
   output logic                        rsp_valid,
   output logic                        rsp_success,
   output logic                        rsp_full_rejected,
   output logic [ECOUNT_W-1:0]         rsp_element_count
);

   ust_mem_req_type    mem_req;
   logic [VALUE_W-1:0] rd_data;

   // sequencer with shared comparator
   ust_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_success       (rsp_success),
      .rsp_full_rejected (rsp_full_rejected),
      .rsp_element_count (rsp_element_count),
      .mem_req           (mem_req),
      .rd_data           (rd_data)
   );

   // entry memory
   ust_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule
